// File: rtl/multi_reader_message_ring_unit_defines.svh
// assertion macros for the message ring unit
`ifndef MULTI_READER_MESSAGE_RING_UNIT_DEFINES_SVH
`define MULTI_READER_MESSAGE_RING_UNIT_DEFINES_SVH

// condition holds at every clock edge out of reset
`define MRR_ASSERT_ALWAYS(lbl, cond) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) \
        else $error("mrr assertion failed");

// condition implies a consequence in the next cycle
`define MRR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("mrr assertion failed");

`endif

// File: rtl/mrr_pkg.sv
// shared constants, codes and types of the message ring unit
package mrr_pkg;

    localparam int READER_SLOTS   = 8;
    localparam int RING_MAX_BYTES = 65536;
    localparam int TAG_DEPTH      = RING_MAX_BYTES / 8;
    localparam int TAG_AW         = $clog2(TAG_DEPTH);
    localparam int OFF_W          = $clog2(RING_MAX_BYTES);
    localparam int RING_W         = OFF_W + 1;
    localparam int CNT_W          = $clog2(READER_SLOTS + 1);
    localparam int STEP_W         = $clog2(TAG_DEPTH + 3);
    localparam int TAG_W          = 18;
    localparam int LAP_W          = 32;

    localparam logic [TAG_W-1:0]  WRAP_TAG   = '1;
    localparam logic [STEP_W-1:0] STEP_LIMIT = STEP_W'(TAG_DEPTH + 2);
    localparam logic [RING_W-1:0] RING_MIN   = RING_W'(64);
    localparam logic [RING_W-1:0] RING_MAX   = RING_W'(RING_MAX_BYTES);

    typedef enum logic [2:0] {
        FN_SEND    = 3'd0,
        FN_RECV    = 3'd1,
        FN_SUB     = 3'd2,
        FN_QUERY   = 3'd3,
        FN_RESTART = 3'd4
    } mrr_func_t;

    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_NO_MSG  = 2'd1,
        ST_TOO_BIG = 2'd2,
        ST_NOT_SUB = 2'd3
    } mrr_status_t;

    typedef enum logic [0:0] {
        CFG_RING_BYTES = 1'b0,
        CFG_CONFLATE   = 1'b1
    } mrr_cfg_idx_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_SEND_WRAP,
        S_SEND_PUT,
        S_RECV_CHK,
        S_RECV_TAG
    } mrr_state_t;

endpackage

// File: rtl/multi_reader_message_ring_unit.sv
// subscribe, query, restart, unknown codes and rejects answer from dispatch; send
// writes a wrap tag if needed, then the size tag; receive checks for data, then reads a
// tag, back to the check per wrap tag followed or message skipped in conflate mode (one
// tag memory read each); one transaction in flight; the next is accepted early but
// waits for the output register; reset (synchronous, aresetn low): pointers, laps,
// reader slots and control registers reset; tag memory not cleared, no clearing pass
`include "multi_reader_message_ring_unit_defines.svh"

module multi_reader_message_ring_unit
    import mrr_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [0:0]  cfg_index,
    input  logic [16:0] cfg_data,
    // requests
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,    // reader[2:0], msg_bytes[18:3], zero fill
    input  logic [2:0]  s_tuser,    // func[2:0]
    // results
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata     // status[1:0], has_message[2], payload_offset[18:3],
                                    // payload_bytes[34:19], slot_given[37:35],
                                    // evicted_all[38], zero fill
);

    mrr_state_t state_reg, state_next;

    logic [2:0]        func_reg, func_next;
    logic [2:0]        rdr_reg, rdr_next;
    logic [15:0]       len_reg, len_next;

    logic [RING_W-1:0] ring_bytes_reg, ring_bytes_next;
    logic [7:0]        conflate_reg, conflate_next;

    logic [OFF_W-1:0]  wo_reg, wo_next;
    logic [LAP_W-1:0]  wlap_reg, wlap_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [OFF_W-1:0]  roff_reg [READER_SLOTS];
    logic [OFF_W-1:0]  roff_next [READER_SLOTS];
    logic [LAP_W-1:0]  rlap_reg [READER_SLOTS];
    logic [LAP_W-1:0]  rlap_next [READER_SLOTS];
    logic [READER_SLOTS-1:0] rval_reg, rval_next;
    logic [STEP_W-1:0] steps_reg, steps_next;

    logic        m_valid_reg, m_valid_next;
    logic [1:0]  o_status_reg, o_status_next;
    logic        o_has_reg, o_has_next;
    logic [15:0] o_off_reg, o_off_next;
    logic [15:0] o_bytes_reg, o_bytes_next;
    logic [2:0]  o_slot_reg, o_slot_next;
    logic        o_evict_reg, o_evict_next;

    // tag memory
    logic [TAG_W-1:0]  tag_mem [TAG_DEPTH];
    logic              mem_we, mem_re;
    logic [TAG_AW-1:0] mem_waddr, mem_raddr;
    logic [TAG_W-1:0]  mem_wdata, mem_rdata_reg;

    logic              in_fire;
    logic [RING_W-1:0] ring_eff;
    logic [RING_W-1:0] total;
    logic [RING_W+1:0] total3;
    logic [RING_W+1:0] wrap_sum;
    logic [OFF_W+1:0]  end_sum;
    logic [OFF_W-1:0]  end_off;
    logic [OFF_W-1:0]  rp;
    logic [OFF_W+1:0]  next_sum;
    logic [CNT_W-1:0]  sub_id;

    assign in_fire   = s_tvalid && s_tready;
    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = {1'b0, o_evict_reg, o_slot_reg, o_bytes_reg, o_off_reg,
                        o_has_reg, o_status_reg};

    // effective ring size
    always_comb begin
        ring_eff = ring_bytes_reg;
        if (ring_eff < RING_MIN) ring_eff = RING_MIN;
        if (ring_eff > RING_MAX) ring_eff = RING_MAX;
        ring_eff = ring_eff & ~RING_W'(7);
    end

    // send sizing
    assign total    = (RING_W'(len_reg) + RING_W'(15)) & ~RING_W'(7);
    assign total3   = (RING_W+2)'(total) + ((RING_W+2)'(total) << 1);
    assign wrap_sum = (RING_W+2)'(wo_reg) + (RING_W+2)'(total) + (RING_W+2)'(8);
    assign end_sum  = ((OFF_W+2)'(wo_reg) + (OFF_W+2)'(len_reg) + (OFF_W+2)'(15))
                      & ~(OFF_W+2)'(7);
    assign end_off  = end_sum[OFF_W-1:0];

    // receive pointer and next message position
    assign rp       = rval_reg[rdr_reg] ? roff_reg[rdr_reg] : wo_reg;
    assign next_sum = ((OFF_W+2)'(roff_reg[rdr_reg]) + (OFF_W+2)'(mem_rdata_reg[RING_W-1:0])
                      + (OFF_W+2)'(15)) & ~(OFF_W+2)'(7);
    assign sub_id   = (cnt_reg >= CNT_W'(READER_SLOTS)) ? '0 : cnt_reg;

    // next state and datapath
    always_comb begin
        state_next      = state_reg;
        func_next       = func_reg;
        rdr_next        = rdr_reg;
        len_next        = len_reg;
        ring_bytes_next = ring_bytes_reg;
        conflate_next   = conflate_reg;
        wo_next         = wo_reg;
        wlap_next       = wlap_reg;
        cnt_next        = cnt_reg;
        roff_next       = roff_reg;
        rlap_next       = rlap_reg;
        rval_next       = rval_reg;
        steps_next      = steps_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        o_status_next   = o_status_reg;
        o_has_next      = o_has_reg;
        o_off_next      = o_off_reg;
        o_bytes_next    = o_bytes_reg;
        o_slot_next     = o_slot_reg;
        o_evict_next    = o_evict_reg;
        mem_we          = 1'b0;
        mem_waddr       = wo_reg[OFF_W-1:3];
        mem_wdata       = TAG_W'(len_reg);
        mem_re          = 1'b0;
        mem_raddr       = rp[OFF_W-1:3];

        // configuration transaction
        if (cfg_valid) begin
            unique case (cfg_index)
                CFG_RING_BYTES: ring_bytes_next = cfg_data;
                CFG_CONFLATE:   conflate_next   = cfg_data[7:0];
                default: ;
            endcase
        end

        unique case (state_reg)
            S_IDLE: begin
                if (in_fire) begin
                    func_next  = s_tuser;
                    rdr_next   = s_tdata[2:0];
                    len_next   = s_tdata[18:3];
                    state_next = S_DISPATCH;
                end
            end

            S_DISPATCH: begin
                if (!m_valid_reg) begin
                    m_valid_next  = 1'b1;
                    o_status_next = ST_DONE;
                    o_has_next    = 1'b0;
                    o_off_next    = '0;
                    o_bytes_next  = '0;
                    o_slot_next   = '0;
                    o_evict_next  = 1'b0;
                    state_next    = S_IDLE;
                    case (func_reg)
                        FN_SEND: begin
                            if (total3 > (RING_W+2)'(ring_eff)) begin
                                o_status_next = ST_TOO_BIG;
                            end else begin
                                m_valid_next = 1'b0;
                                state_next   = (wrap_sum >= (RING_W+2)'(ring_eff))
                                               ? S_SEND_WRAP : S_SEND_PUT;
                            end
                        end
                        FN_RECV: begin
                            if (CNT_W'(rdr_reg) >= cnt_reg) begin
                                o_status_next = ST_NOT_SUB;
                            end else begin
                                m_valid_next = 1'b0;
                                steps_next   = '0;
                                state_next   = S_RECV_CHK;
                            end
                        end
                        FN_SUB: begin
                            if (cnt_reg >= CNT_W'(READER_SLOTS)) begin
                                rval_next    = '0;
                                o_evict_next = 1'b1;
                            end
                            cnt_next = sub_id + CNT_W'(1);
                            rval_next[sub_id[2:0]] = 1'b1;
                            roff_next[sub_id[2:0]] = wo_reg;
                            rlap_next[sub_id[2:0]] = wlap_reg;
                            o_slot_next = sub_id[2:0];
                        end
                        FN_QUERY: begin
                            if (CNT_W'(rdr_reg) >= cnt_reg) begin
                                o_status_next = ST_NOT_SUB;
                            end else begin
                                if (!rval_reg[rdr_reg]) begin
                                    rval_next[rdr_reg] = 1'b1;
                                    roff_next[rdr_reg] = wo_reg;
                                    rlap_next[rdr_reg] = wlap_reg;
                                end
                                o_has_next = (rp != wo_reg);
                            end
                        end
                        FN_RESTART: begin
                            cnt_next  = '0;
                            rval_next = '0;
                        end
                        default: ;
                    endcase
                end
            end

            // wrap tag, invalidate lapped readers past the write pointer
            S_SEND_WRAP: begin
                mem_we    = 1'b1;
                mem_wdata = WRAP_TAG;
                for (int i = 0; i < READER_SLOTS; i++) begin
                    if (CNT_W'(i) < cnt_reg && roff_reg[i] > wo_reg
                        && rlap_reg[i] != wlap_reg)
                        rval_next[i] = 1'b0;
                end
                wo_next    = '0;
                wlap_next  = wlap_reg + LAP_W'(1);
                state_next = S_SEND_PUT;
            end

            // size tag, invalidate lapped readers inside the new message
            S_SEND_PUT: begin
                mem_we = 1'b1;
                for (int i = 0; i < READER_SLOTS; i++) begin
                    if (CNT_W'(i) < cnt_reg && roff_reg[i] >= wo_reg
                        && (OFF_W+2)'(roff_reg[i]) < end_sum && rlap_reg[i] != wlap_reg)
                        rval_next[i] = 1'b0;
                end
                wo_next       = end_off;
                m_valid_next  = 1'b1;
                o_status_next = ST_DONE;
                o_off_next    = wo_reg + OFF_W'(8);
                o_bytes_next  = len_reg;
                state_next    = S_IDLE;
            end

            // resync if needed, check for data, fetch tag
            S_RECV_CHK: begin
                rval_next[rdr_reg] = 1'b1;
                if (!rval_reg[rdr_reg] || steps_reg == STEP_LIMIT) begin
                    roff_next[rdr_reg] = wo_reg;
                    rlap_next[rdr_reg] = wlap_reg;
                end
                if (steps_reg == STEP_LIMIT || rp == wo_reg) begin
                    m_valid_next  = 1'b1;
                    o_status_next = ST_NO_MSG;
                    state_next    = S_IDLE;
                end else begin
                    mem_re     = 1'b1;
                    state_next = S_RECV_TAG;
                end
            end

            // interpret the tag
            S_RECV_TAG: begin
                if (mem_rdata_reg == WRAP_TAG) begin
                    rlap_next[rdr_reg] = rlap_reg[rdr_reg] + LAP_W'(1);
                    roff_next[rdr_reg] = '0;
                    steps_next         = steps_reg + STEP_W'(1);
                    state_next         = S_RECV_CHK;
                end else if (mem_rdata_reg >= TAG_W'(ring_eff)) begin
                    roff_next[rdr_reg] = wo_reg;
                    rlap_next[rdr_reg] = wlap_reg;
                    m_valid_next       = 1'b1;
                    o_status_next      = ST_NO_MSG;
                    state_next         = S_IDLE;
                end else begin
                    roff_next[rdr_reg] = next_sum[OFF_W-1:0];
                    if (conflate_reg[rdr_reg] && next_sum != (OFF_W+2)'(wo_reg)) begin
                        steps_next = steps_reg + STEP_W'(1);
                        state_next = S_RECV_CHK;
                    end else begin
                        m_valid_next  = 1'b1;
                        o_status_next = ST_DONE;
                        o_off_next    = roff_reg[rdr_reg] + OFF_W'(8);
                        o_bytes_next  = mem_rdata_reg[15:0];
                        state_next    = S_IDLE;
                    end
                end
            end

            default: state_next = S_IDLE;
        endcase
    end

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // control and pointer registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ring_bytes_reg <= RING_MAX;
            conflate_reg   <= '0;
            wo_reg         <= '0;
            wlap_reg       <= '0;
            cnt_reg        <= '0;
            rval_reg       <= '0;
            m_valid_reg    <= 1'b0;
            for (int i = 0; i < READER_SLOTS; i++) begin
                roff_reg[i] <= '0;
                rlap_reg[i] <= '0;
            end
        end else begin
            ring_bytes_reg <= ring_bytes_next;
            conflate_reg   <= conflate_next;
            wo_reg         <= wo_next;
            wlap_reg       <= wlap_next;
            cnt_reg        <= cnt_next;
            rval_reg       <= rval_next;
            m_valid_reg    <= m_valid_next;
            roff_reg       <= roff_next;
            rlap_reg       <= rlap_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        func_reg     <= func_next;
        rdr_reg      <= rdr_next;
        len_reg      <= len_next;
        steps_reg    <= steps_next;
        o_status_reg <= o_status_next;
        o_has_reg    <= o_has_next;
        o_off_reg    <= o_off_next;
        o_bytes_reg  <= o_bytes_next;
        o_slot_reg   <= o_slot_next;
        o_evict_reg  <= o_evict_next;
    end

    // tag memory port
    always_ff @(posedge aclk) begin
        if (mem_we) tag_mem[mem_waddr] <= mem_wdata;
        if (mem_re) mem_rdata_reg <= tag_mem[mem_raddr];
    end

    // checks
    `MRR_ASSERT_ALWAYS(a_cnt_range, cnt_reg <= CNT_W'(READER_SLOTS))
    `MRR_ASSERT_ALWAYS(a_wo_aligned, wo_reg[2:0] == 3'd0)
    `MRR_ASSERT_NEXT(a_accept_busy, s_tvalid && s_tready, state_reg == S_DISPATCH)
    `MRR_ASSERT_NEXT(a_tag_follows_read, state_reg == S_RECV_CHK && state_next == S_RECV_TAG,
                     state_reg == S_RECV_TAG && !m_valid_reg)

endmodule

// File: sim/tb_multi_reader_message_ring_unit.sv
// self-checking testbench for the multi-reader message ring unit
module tb_multi_reader_message_ring_unit;
    import mrr_pkg::*;

    // result fields, packed so that status sits in the lowest bits as on m_tdata
    typedef struct packed {
        logic        evicted_all;
        logic [2:0]  slot_given;
        logic [15:0] payload_bytes;
        logic [15:0] payload_offset;
        logic        has_message;
        logic [1:0]  status;
    } ring_result_t;

    typedef struct {
        logic [2:0]   fn;
        logic [2:0]   rd;
        logic [15:0]  len;
        bit           typed;
        ring_result_t want;
    } req_row_t;

    localparam int WATCHDOG_LIMIT = 200000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [0:0]  cfg_index = '0;
    logic [16:0] cfg_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;
    logic [2:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;

    multi_reader_message_ring_unit uut (.*);

    // clock
    always begin
        aclk = 1'b0;
        #10;
        aclk = 1'b1;
        #10;
    end

    // ring model state
    int unsigned  ring_reg;
    int unsigned  conflate_reg;
    int unsigned  wr_off;
    int unsigned  wr_lap;
    int unsigned  sub_count;
    int unsigned  rd_off [READER_SLOTS];
    int unsigned  rd_lap [READER_SLOTS];
    bit           rd_vld [READER_SLOTS];
    logic [17:0]  tag_mem [TAG_DEPTH];
    bit           tag_set [TAG_DEPTH];

    ring_result_t pending_results[$];
    int           errors = 0;
    int           n_items = 0;
    int           n_results = 0;
    int           n_phases = 0;
    bit           idling_on = 1'b1;
    int           stall_cycles = 0;

    function automatic int unsigned ring_span();
        int unsigned r;
        r = ring_reg;
        if (r < 64) r = 64;
        if (r > RING_MAX_BYTES) r = RING_MAX_BYTES;
        return r & ~32'd7;
    endfunction

    function automatic void resync_reader(int unsigned r);
        rd_vld[r] = 1'b1;
        rd_off[r] = wr_off;
        rd_lap[r] = wr_lap;
    endfunction

    function automatic void put_tag(int unsigned ptr, logic [17:0] val);
        tag_mem[(ptr >> 3) % TAG_DEPTH] = val;
        tag_set[(ptr >> 3) % TAG_DEPTH] = 1'b1;
    endfunction

    // send: wrap if needed, invalidate lapped readers in the overwritten span
    function automatic ring_result_t ring_send(int unsigned len);
        ring_result_t res;
        int unsigned ring, total, wp, n, stop;
        res = '0;
        ring = ring_span();
        total = (len + 15) & ~32'd7;
        wp = wr_off;
        n = sub_count < READER_SLOTS ? sub_count : READER_SLOTS;
        if (3 * total > ring) begin
            res.status = ST_TOO_BIG;
            return res;
        end
        if (longint'(ring) - longint'(wp) - longint'(total) - 8 <= 0) begin
            put_tag(wp, WRAP_TAG);
            for (int i = 0; i < n; i++)
                if (rd_off[i] > wp && rd_lap[i] != wr_lap) rd_vld[i] = 1'b0;
            wp = 0;
            wr_lap = wr_lap + 1;
        end
        stop = (wp + 15 + len) & ~32'd7;
        for (int i = 0; i < n; i++)
            if (rd_off[i] >= wp && rd_off[i] < stop && rd_lap[i] != wr_lap) rd_vld[i] = 1'b0;
        put_tag(wp, 18'(len));
        wr_off = stop;
        res.status = ST_DONE;
        res.payload_offset = 16'(wp + 8);
        res.payload_bytes = 16'(len);
        return res;
    endfunction

    // receive walk; flags a read of a never-written tag word and then leaves state alone
    function automatic ring_result_t ring_recv(int unsigned r, output bit unsafe);
        ring_result_t res;
        int unsigned ring, steps, rp, idx, nxt, sv_off, sv_lap;
        bit sv_vld, fin, corrupt, conf;
        logic [17:0] tag;
        res = '0;
        unsafe = 1'b0;
        ring = ring_span();
        conf = conflate_reg[r];
        sv_off = rd_off[r];
        sv_lap = rd_lap[r];
        sv_vld = rd_vld[r];
        fin = 1'b0;
        corrupt = 1'b0;
        steps = 0;
        res.status = ST_NO_MSG;
        while (!fin && steps < TAG_DEPTH + 2) begin
            steps++;
            if (!rd_vld[r]) resync_reader(r);
            rp = rd_off[r];
            if (rp == wr_off) begin
                fin = 1'b1;
            end else begin
                idx = (rp >> 3) % TAG_DEPTH;
                tag = tag_mem[idx];
                if (!tag_set[idx]) begin
                    unsafe = 1'b1;
                    fin = 1'b1;
                end else if (tag == WRAP_TAG) begin
                    rd_lap[r] = rd_lap[r] + 1;
                    rd_off[r] = 0;
                end else if (tag >= ring) begin
                    corrupt = 1'b1;
                    fin = 1'b1;
                end else begin
                    nxt = (rp + 15 + tag) & ~32'd7;
                    rd_off[r] = nxt;
                    if (!(conf && nxt != wr_off)) begin
                        res.status = ST_DONE;
                        res.payload_offset = 16'(rp + 8);
                        res.payload_bytes = 16'(tag);
                        fin = 1'b1;
                    end
                end
            end
        end
        if (!fin || corrupt) begin
            resync_reader(r);
            res = '0;
            res.status = ST_NO_MSG;
        end
        if (unsafe) begin
            rd_off[r] = sv_off;
            rd_lap[r] = sv_lap;
            rd_vld[r] = sv_vld;
        end
        return res;
    endfunction

    // one request against the ring model
    function automatic ring_result_t ring_predict(logic [2:0] fn, logic [2:0] rd,
                                                  logic [15:0] len, output bit unsafe);
        ring_result_t res;
        res = '0;
        unsafe = 1'b0;
        case (fn)
            FN_SEND: res = ring_send(len);
            FN_RECV: begin
                if (rd >= sub_count) res.status = ST_NOT_SUB;
                else res = ring_recv(rd, unsafe);
            end
            FN_SUB: begin
                if (sub_count + 1 > READER_SLOTS) begin
                    sub_count = 0;
                    for (int i = 0; i < READER_SLOTS; i++) rd_vld[i] = 1'b0;
                    res.evicted_all = 1'b1;
                end
                res.slot_given = 3'(sub_count);
                resync_reader(sub_count);
                sub_count++;
            end
            FN_QUERY: begin
                if (rd >= sub_count) begin
                    res.status = ST_NOT_SUB;
                end else begin
                    if (!rd_vld[rd]) resync_reader(rd);
                    res.has_message = rd_off[rd] != wr_off;
                end
            end
            FN_RESTART: begin
                sub_count = 0;
                for (int i = 0; i < READER_SLOTS; i++) rd_vld[i] = 1'b0;
            end
            default: ;
        endcase
        return res;
    endfunction

    // drive one request until accepted
    task automatic drive_request(logic [2:0] fn, logic [2:0] rd, logic [15:0] len);
        if (idling_on && $urandom_range(99) < 31) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= fn;
        s_tdata <= {5'd0, len, rd};
        do @(posedge aclk); while (!s_tready);
        n_items++;
    endtask

    // predict, skip if it would touch an unwritten tag, then issue
    task automatic issue(logic [2:0] fn, logic [2:0] rd, logic [15:0] len);
        ring_result_t res;
        bit unsafe;
        res = ring_predict(fn, rd, len, unsafe);
        if (unsafe) return;
        pending_results.push_back(res);
        drive_request(fn, rd, len);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (24) @(posedge aclk);
    endtask

    task automatic write_reg(mrr_cfg_idx_t idx, logic [16:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge aclk);
        if (idx == CFG_RING_BYTES) ring_reg = val;
        else conflate_reg = val[7:0];
    endtask

    // receiver stalls
    always @(posedge aclk) begin
        m_tready <= idling_on ? ($urandom_range(99) >= 31) : 1'b1;
    end

    // result checker and watchdog
    always @(posedge aclk) begin
        ring_result_t got, want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got = m_tdata[38:0];
                n_results++;
                if (pending_results.size() == 0) begin
                    $error("result with no expectation: %h", m_tdata);
                    errors++;
                end else begin
                    want = pending_results.pop_front();
                    if (got.status !== want.status) begin
                        $error("status exp %0d got %0d", want.status, got.status);
                        errors++;
                    end
                    if (got.has_message !== want.has_message) begin
                        $error("has_message exp %0d got %0d", want.has_message,
                               got.has_message);
                        errors++;
                    end
                    if (got.payload_offset !== want.payload_offset) begin
                        $error("payload_offset exp %0d got %0d", want.payload_offset,
                               got.payload_offset);
                        errors++;
                    end
                    if (got.payload_bytes !== want.payload_bytes) begin
                        $error("payload_bytes exp %0d got %0d", want.payload_bytes,
                               got.payload_bytes);
                        errors++;
                    end
                    if (got.slot_given !== want.slot_given) begin
                        $error("slot_given exp %0d got %0d", want.slot_given, got.slot_given);
                        errors++;
                    end
                    if (got.evicted_all !== want.evicted_all) begin
                        $error("evicted_all exp %0d got %0d", want.evicted_all,
                               got.evicted_all);
                        errors++;
                    end
                end
            end
            if ((m_tvalid && m_tready) || (s_tvalid && s_tready) || (cfg_valid && cfg_ready))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles == WATCHDOG_LIMIT) begin
                $display("tb_multi_reader_message_ring_unit: done, errors");
                $finish;
            end
        end
    end

    // directed rows: typed results where obvious, the rest from the model
    req_row_t dir_rows[] = '{
        '{FN_QUERY,   3'd0, 16'd0,     1'b1, '{1'b0, 3'd0, 16'd0, 16'd0, 1'b0, ST_NOT_SUB}},
        '{FN_RECV,    3'd0, 16'd0,     1'b1, '{1'b0, 3'd0, 16'd0, 16'd0, 1'b0, ST_NOT_SUB}},
        '{3'd5,       3'd7, 16'hFFFF,  1'b1, '0},
        '{3'd7,       3'd0, 16'd0,     1'b1, '0},
        '{FN_SEND,    3'd0, 16'hFFFF,  1'b1, '{1'b0, 3'd0, 16'd0, 16'd0, 1'b0, ST_TOO_BIG}},
        '{FN_SUB,     3'd0, 16'd0,     1'b1, '{1'b0, 3'd0, 16'd0, 16'd0, 1'b0, ST_DONE}},
        '{FN_RECV,    3'd0, 16'd0,     1'b1, '{1'b0, 3'd0, 16'd0, 16'd0, 1'b0, ST_NO_MSG}},
        '{FN_QUERY,   3'd0, 16'd0,     1'b1, '{1'b0, 3'd0, 16'd0, 16'd0, 1'b0, ST_DONE}},
        '{FN_SEND,    3'd0, 16'd0,     1'b1, '{1'b0, 3'd0, 16'd0, 16'd8, 1'b0, ST_DONE}},
        '{FN_QUERY,   3'd0, 16'd0,     1'b1, '{1'b0, 3'd0, 16'd0, 16'd0, 1'b1, ST_DONE}},
        '{FN_RECV,    3'd0, 16'd0,     1'b1, '{1'b0, 3'd0, 16'd0, 16'd8, 1'b0, ST_DONE}},
        '{FN_SEND,    3'd0, 16'd21832, 1'b0, '0},
        '{FN_SEND,    3'd0, 16'd21833, 1'b1, '{1'b0, 3'd0, 16'd0, 16'd0, 1'b0, ST_TOO_BIG}},
        '{FN_SEND,    3'd0, 16'd21832, 1'b0, '0},
        '{FN_RECV,    3'd0, 16'd0,     1'b0, '0},
        '{FN_SUB,     3'd0, 16'd0,     1'b0, '0},
        '{FN_SUB,     3'd0, 16'd0,     1'b0, '0},
        '{FN_SUB,     3'd0, 16'd0,     1'b0, '0},
        '{FN_SUB,     3'd0, 16'd0,     1'b0, '0},
        '{FN_SUB,     3'd0, 16'd0,     1'b0, '0},
        '{FN_SUB,     3'd0, 16'd0,     1'b0, '0},
        '{FN_SUB,     3'd0, 16'd0,     1'b0, '0},
        '{FN_SUB,     3'd0, 16'd0,     1'b1, '{1'b1, 3'd0, 16'd0, 16'd0, 1'b0, ST_DONE}},
        '{FN_RESTART, 3'd0, 16'd0,     1'b1, '0},
        '{FN_RECV,    3'd0, 16'd0,     1'b1, '{1'b0, 3'd0, 16'd0, 16'd0, 1'b0, ST_NOT_SUB}}
    };

    // configuration phases for the random part, extremes included
    logic [16:0] phase_ring [8] = '{17'd64, 17'd0, 17'h1FFFF, 17'd256, 17'd1007,
                                    17'd4096, 17'd520, 17'd65536};
    logic [16:0] phase_conf [8] = '{17'h000FF, 17'h1FF55, 17'h000AA, 17'd0, 17'h0000F,
                                    17'h000F0, 17'h000FF, 17'd0};

    // stimulus
    initial begin
        ring_result_t res;
        bit unsafe;
        int unsigned ring, top, pick, budget;
        logic [2:0] fn, rd;
        logic [15:0] len;
        ring_reg = 65536;
        conflate_reg = 0;
        wr_off = 0;
        wr_lap = 0;
        sub_count = 0;
        for (int i = 0; i < READER_SLOTS; i++) begin
            rd_off[i] = 0;
            rd_lap[i] = 0;
            rd_vld[i] = 1'b0;
        end
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_rows[k]) begin
            res = ring_predict(dir_rows[k].fn, dir_rows[k].rd, dir_rows[k].len, unsafe);
            pending_results.push_back(dir_rows[k].typed ? dir_rows[k].want : res);
            drive_request(dir_rows[k].fn, dir_rows[k].rd, dir_rows[k].len);
        end

        foreach (phase_ring[p]) begin
            wait_drained();
            write_reg(CFG_RING_BYTES, phase_ring[p]);
            write_reg(CFG_CONFLATE, phase_conf[p]);
            n_phases++;
            idling_on = (p != 3);
            ring = ring_span();
            top = ((ring / 3) & ~32'd7) - 8;
            budget = n_items + 215;
            issue(FN_SUB, 3'd0, 16'd0);
            issue(FN_SUB, 3'd0, 16'd0);
            while (n_items < budget) begin
                pick = $urandom_range(99);
                if (pick < 36) fn = FN_SEND;
                else if (pick < 72) fn = FN_RECV;
                else if (pick < 84) fn = FN_QUERY;
                else if (pick < 92) fn = FN_SUB;
                else if (pick < 95) fn = FN_RESTART;
                else fn = 3'($urandom_range(5, 7));
                if (sub_count > 0 && $urandom_range(7) != 0)
                    rd = 3'($urandom_range(sub_count - 1));
                else
                    rd = 3'($urandom_range(7));
                pick = $urandom_range(99);
                if (pick < 70) len = 16'($urandom_range(ring / 8));
                else if (pick < 82) len = 16'($urandom);
                else if (pick < 88) len = 16'(top);
                else if (pick < 94) len = 16'(top + 1);
                else len = (pick & 1) ? 16'hFFFF : 16'd0;
                issue(fn, rd, len);
                // the sender holds off once mid-run until everything is back
                if (p == 5 && n_items == budget - 100) wait_drained();
            end
        end

        wait_drained();
        $display("covered %0d requests and %0d results over %0d register settings",
                 n_items, n_results, n_phases);
        $display("sends, receives with wrap and conflate, queries, evictions, restarts");
        if (errors == 0) begin
            $display("tb_multi_reader_message_ring_unit: done, clean");
        end else begin
            $display("tb_multi_reader_message_ring_unit: done, errors");
        end
        $finish;
    end

endmodule

// File: files.f
+incdir+rtl
rtl/mrr_pkg.sv
rtl/multi_reader_message_ring_unit.sv
sim/tb_multi_reader_message_ring_unit.sv
